// ----- rtl/rhsv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_pkg
// shared widths, constants and types of the rgb888 to hsv/rgb565 converter
// ----------------------------------------------------------------------------
package rhsv_pkg;

	// restoring divider: numerators up to 100*255, divisors 8 bits, quotients to 100
	localparam int unsigned NUM_W      = 15;
	localparam int unsigned DEN_W      = 8;
	localparam int unsigned QUO_W      = 7;
	localparam int unsigned DIV_STAGES = QUO_W;

	// reciprocal estimates, scaled by 2^16, corrected by one compare afterwards
	localparam int unsigned RCP_SHIFT = 16;
	localparam logic [13:0] RCP_RB    = 14'((65536 * 1000) / 8225);
	localparam logic [13:0] RCP_G     = 14'((65536 * 1000) / 4047);
	localparam logic [13:0] RCP_V     = 14'(65536 / 5);

	localparam logic [9:0]  SCALE_565 = 10'd1000;
	localparam logic [13:0] DIV_RB    = 14'd8225;
	localparam logic [11:0] DIV_G     = 12'd4047;
	localparam logic [2:0]  DIV_V     = 3'd5;
	localparam logic [5:0]  HUE_STEP  = 6'd60;
	localparam logic [6:0]  PERCENT   = 7'd100;

	localparam logic [8:0]  HUE_BASE_RED   = 9'd0;
	localparam logic [8:0]  HUE_BASE_GREEN = 9'd120;
	localparam logic [8:0]  HUE_BASE_BLUE  = 9'd240;
	localparam logic [8:0]  HUE_FULL       = 9'd360;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// fields that ride alongside the divider
	typedef struct packed {
		sector_t     sector;
		logic        neg;
		logic        grey;
		logic        black;
		logic [15:0] rgb565;
		logic [6:0]  bright;
	} side_t;

endpackage

// ----- rtl/rhsv_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhsv_divider
// pipelined restoring divider, one quotient bit per stage, two lanes (hue and
// saturation) in lock step with the side fields carried alongside
// ----------------------------------------------------------------------------
module rhsv_divider (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [rhsv_pkg::NUM_W-1:0]          num_h,
	input  logic [rhsv_pkg::DEN_W-1:0]          den_h,
	input  logic [rhsv_pkg::NUM_W-1:0]          num_s,
	input  logic [rhsv_pkg::DEN_W-1:0]          den_s,
	input  rhsv_pkg::side_t                     side_in,
	output logic                                out_valid,
	output logic [rhsv_pkg::QUO_W-1:0]          quo_h,
	output logic                                rem_nz_h,
	output logic [rhsv_pkg::QUO_W-1:0]          quo_s,
	output rhsv_pkg::side_t                     side_out
);

	localparam int unsigned S = rhsv_pkg::DIV_STAGES;

	logic                              valid_s  [0:S-1];
	logic [rhsv_pkg::NUM_W-1:0]        h_rem_s  [0:S-1];
	logic [rhsv_pkg::DEN_W-1:0]        h_den_s  [0:S-1];
	logic [rhsv_pkg::QUO_W-1:0]        h_quo_s  [0:S-1];
	logic [rhsv_pkg::NUM_W-1:0]        s_rem_s  [0:S-1];
	logic [rhsv_pkg::DEN_W-1:0]        s_den_s  [0:S-1];
	logic [rhsv_pkg::QUO_W-1:0]        s_quo_s  [0:S-1];
	rhsv_pkg::side_t                   side_s   [0:S-1];

	genvar i;
	generate
		for (i = 0; i < S; i++) begin : g_stage
			logic                          v_in;
			logic [rhsv_pkg::NUM_W-1:0]    h_rem_in, s_rem_in, h_trial, s_trial;
			logic [rhsv_pkg::DEN_W-1:0]    h_den_in, s_den_in;
			logic [rhsv_pkg::QUO_W-1:0]    h_quo_in, s_quo_in;
			rhsv_pkg::side_t               side_in_i;
			logic                          h_ge, s_ge;

			if (i == 0) begin : g_first
				assign v_in      = in_valid;
				assign h_rem_in  = num_h;
				assign h_den_in  = den_h;
				assign h_quo_in  = '0;
				assign s_rem_in  = num_s;
				assign s_den_in  = den_s;
				assign s_quo_in  = '0;
				assign side_in_i = side_in;
			end else begin : g_next
				assign v_in      = valid_s[i-1];
				assign h_rem_in  = h_rem_s[i-1];
				assign h_den_in  = h_den_s[i-1];
				assign h_quo_in  = h_quo_s[i-1];
				assign s_rem_in  = s_rem_s[i-1];
				assign s_den_in  = s_den_s[i-1];
				assign s_quo_in  = s_quo_s[i-1];
				assign side_in_i = side_s[i-1];
			end

			// divisor shifted to the weight of this stage's quotient bit
			assign h_trial = rhsv_pkg::NUM_W'(h_den_in) << (S - 1 - i);
			assign s_trial = rhsv_pkg::NUM_W'(s_den_in) << (S - 1 - i);
			assign h_ge    = h_rem_in >= h_trial;
			assign s_ge    = s_rem_in >= s_trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[i] <= 1'b0;
				end else if (en) begin
					valid_s[i] <= v_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					h_rem_s[i] <= h_ge ? h_rem_in - h_trial : h_rem_in;
					h_den_s[i] <= h_den_in;
					h_quo_s[i] <= {h_quo_in[rhsv_pkg::QUO_W-2:0], h_ge};
					s_rem_s[i] <= s_ge ? s_rem_in - s_trial : s_rem_in;
					s_den_s[i] <= s_den_in;
					s_quo_s[i] <= {s_quo_in[rhsv_pkg::QUO_W-2:0], s_ge};
					side_s[i]  <= side_in_i;
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[S-1];
	assign quo_h     = h_quo_s[S-1];
	assign rem_nz_h  = |h_rem_s[S-1];
	assign quo_s     = s_quo_s[S-1];
	assign side_out  = side_s[S-1];

endmodule

// ----- rtl/rgb888_to_hsv_rgb565.sv -----
`timescale 1ns / 1ps
// path: input, extremes, correction, seven-stage divider and output registers
// throughput: one transaction per cycle; the whole pipeline holds while a
//   finished result waits on out_ready
// reset: arst_n clears every stage valid bit, data registers are not reset
// ----------------------------------------------------------------------------
// rgb888_to_hsv_rgb565
// converts one 8-bit rgb sample to a packed rgb565 word and hue, saturation
// and value, fully pipelined
// ----------------------------------------------------------------------------
module rgb888_to_hsv_rgb565 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] rgb565,
	output logic [8:0]  hue,
	output logic [6:0]  saturation,
	output logic [6:0]  brightness
);

	logic en;

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] red_s1, green_s1, blue_s1;

	// stage 2: extremes, sector and reciprocal estimates
	logic             valid_s2;
	logic [7:0]       red_s2, green_s2, blue_s2, mx_s2, d_s2, mag_s2;
	rhsv_pkg::sector_t sector_s2;
	logic             neg_s2;
	logic [4:0]       rq_s2, bq_s2;
	logic [5:0]       gq_s2;
	logic [6:0]       vq_s2;

	// stage 3: corrected quotients and divider operands
	logic                        valid_s3;
	logic [rhsv_pkg::NUM_W-1:0]  nh_s3, ns_s3;
	logic [7:0]                  d_s3, mx_s3;
	rhsv_pkg::side_t             side_s3;

	// stage 11: output register
	logic        valid_s11;
	logic [15:0] rgb565_s11;
	logic [8:0]  hue_s11;
	logic [6:0]  sat_s11, bright_s11;

	assign en       = !valid_s11 || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	// ---- stage 2 logic ----
	logic [7:0]        mx_c, mn_c, hi_c, lo_c;
	rhsv_pkg::sector_t sector_c;
	logic [20:0]       rp_c, bp_c;
	logic [21:0]       gp_c;
	logic [22:0]       vp_c;

	always_comb begin
		mx_c = (red_s1 > green_s1) ? red_s1 : green_s1;
		mx_c = (mx_c > blue_s1) ? mx_c : blue_s1;
		mn_c = (red_s1 < green_s1) ? red_s1 : green_s1;
		mn_c = (mn_c < blue_s1) ? mn_c : blue_s1;
		// ties go blue over green over red
		if (blue_s1 == mx_c) begin
			sector_c = rhsv_pkg::SEC_BLUE;
		end else if (green_s1 == mx_c) begin
			sector_c = rhsv_pkg::SEC_GREEN;
		end else begin
			sector_c = rhsv_pkg::SEC_RED;
		end
		case (sector_c)
			rhsv_pkg::SEC_BLUE: begin
				hi_c = red_s1;
				lo_c = green_s1;
			end
			rhsv_pkg::SEC_GREEN: begin
				hi_c = blue_s1;
				lo_c = red_s1;
			end
			default: begin
				hi_c = green_s1;
				lo_c = blue_s1;
			end
		endcase
		rp_c = 21'(red_s1) * 21'(rhsv_pkg::RCP_RB);
		bp_c = 21'(blue_s1) * 21'(rhsv_pkg::RCP_RB);
		gp_c = 22'(green_s1) * 22'(rhsv_pkg::RCP_G);
		vp_c = 23'({mx_c, 1'b0}) * 23'(rhsv_pkg::RCP_V);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s2    <= red_s1;
			green_s2  <= green_s1;
			blue_s2   <= blue_s1;
			mx_s2     <= mx_c;
			d_s2      <= mx_c - mn_c;
			sector_s2 <= sector_c;
			neg_s2    <= hi_c < lo_c;
			mag_s2    <= (hi_c < lo_c) ? lo_c - hi_c : hi_c - lo_c;
			rq_s2     <= rp_c[rhsv_pkg::RCP_SHIFT +: 5];
			bq_s2     <= bp_c[rhsv_pkg::RCP_SHIFT +: 5];
			gq_s2     <= gp_c[rhsv_pkg::RCP_SHIFT +: 6];
			vq_s2     <= vp_c[rhsv_pkg::RCP_SHIFT +: 7];
		end
	end

	// ---- stage 3 logic: estimate correction ----
	logic [17:0] r_rem_c, b_rem_c, g_rem_c;
	logic [8:0]  v_rem_c;
	logic [4:0]  r5_c, b5_c;
	logic [5:0]  g6_c;
	logic [6:0]  v_c;

	always_comb begin
		r_rem_c = 18'(red_s2) * 18'(rhsv_pkg::SCALE_565) - 18'(rq_s2) * 18'(rhsv_pkg::DIV_RB);
		b_rem_c = 18'(blue_s2) * 18'(rhsv_pkg::SCALE_565) - 18'(bq_s2) * 18'(rhsv_pkg::DIV_RB);
		g_rem_c = 18'(green_s2) * 18'(rhsv_pkg::SCALE_565) - 18'(gq_s2) * 18'(rhsv_pkg::DIV_G);
		v_rem_c = {mx_s2, 1'b0} - 9'(vq_s2) * 9'(rhsv_pkg::DIV_V);
		r5_c    = (r_rem_c >= 18'(rhsv_pkg::DIV_RB)) ? rq_s2 + 5'd1 : rq_s2;
		b5_c    = (b_rem_c >= 18'(rhsv_pkg::DIV_RB)) ? bq_s2 + 5'd1 : bq_s2;
		g6_c    = (g_rem_c >= 18'(rhsv_pkg::DIV_G)) ? gq_s2 + 6'd1 : gq_s2;
		v_c     = (v_rem_c >= 9'(rhsv_pkg::DIV_V)) ? vq_s2 + 7'd1 : vq_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nh_s3          <= rhsv_pkg::NUM_W'(mag_s2) * rhsv_pkg::NUM_W'(rhsv_pkg::HUE_STEP);
			ns_s3          <= rhsv_pkg::NUM_W'(d_s2) * rhsv_pkg::NUM_W'(rhsv_pkg::PERCENT);
			d_s3           <= d_s2;
			mx_s3          <= mx_s2;
			side_s3.sector <= sector_s2;
			side_s3.neg    <= neg_s2;
			side_s3.grey   <= d_s2 == 8'd0;
			side_s3.black  <= mx_s2 == 8'd0;
			side_s3.rgb565 <= {r5_c, g6_c, b5_c};
			side_s3.bright <= v_c;
		end
	end

	// ---- stages 4 to 10: division ----
	logic                        div_valid;
	logic [rhsv_pkg::QUO_W-1:0]  div_qh, div_qs;
	logic                        div_nz;
	rhsv_pkg::side_t             div_side;

	rhsv_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s3),
		.num_h     (nh_s3),
		.den_h     (d_s3),
		.num_s     (ns_s3),
		.den_s     (mx_s3),
		.side_in   (side_s3),
		.out_valid (div_valid),
		.quo_h     (div_qh),
		.rem_nz_h  (div_nz),
		.quo_s     (div_qs),
		.side_out  (div_side)
	);

	// ---- stage 11 logic: hue assembly ----
	logic [8:0] q9_c, base_c, hue_c;

	always_comb begin
		q9_c = 9'(div_qh);
		case (div_side.sector)
			rhsv_pkg::SEC_BLUE:  base_c = rhsv_pkg::HUE_BASE_BLUE;
			rhsv_pkg::SEC_GREEN: base_c = rhsv_pkg::HUE_BASE_GREEN;
			default:             base_c = rhsv_pkg::HUE_BASE_RED;
		endcase
		if (div_side.grey) begin
			hue_c = 9'd0;
		end else if (!div_side.neg) begin
			hue_c = base_c + q9_c;
		end else if (div_side.sector == rhsv_pkg::SEC_RED) begin
			// truncated toward zero, then wrapped
			hue_c = (q9_c == 9'd0) ? 9'd0 : rhsv_pkg::HUE_FULL - q9_c;
		end else begin
			// floor of a negative offset: subtract the ceiling
			hue_c = base_c - q9_c - 9'(div_nz);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (en) begin
			valid_s11 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb565_s11 <= div_side.rgb565;
			hue_s11    <= hue_c;
			sat_s11    <= div_side.black ? 7'd0 : div_qs;
			bright_s11 <= div_side.bright;
		end
	end

	assign out_valid  = valid_s11;
	assign rgb565     = rgb565_s11;
	assign hue        = hue_s11;
	assign saturation = sat_s11;
	assign brightness = bright_s11;

endmodule

// ----- dv/tb_rgb888_to_hsv_rgb565.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb888_to_hsv_rgb565
// self-checking bench for the pixel converter: directed corner colours, then
// uniform and shaped random pixels under sender bursts and receiver stalls;
// every result is checked against an in-bench model of the colour maths
// ----------------------------------------------------------------------------
module tb_rgb888_to_hsv_rgb565;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [15:0] rgb565;
		logic [8:0]  hue;
		logic [6:0]  saturation;
		logic [6:0]  brightness;
	} pixel_hsv_t;

	typedef enum logic [1:0] {
		RDY_FREE,
		RDY_RANDOM,
		RDY_PATTERN
	} ready_mode_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [7:0]  red        = 8'd0;
	logic [7:0]  green      = 8'd0;
	logic [7:0]  blue       = 8'd0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [15:0] rgb565;
	logic [8:0]  hue;
	logic [6:0]  saturation;
	logic [6:0]  brightness;

	pixel_hsv_t  expected_hsv[$];
	int          error_count = 0;
	int          cycle_count = 0;

	// sender burst shaping
	int          burst_left = 0;
	int          burst_max  = 20;
	int          gap_max    = 0;

	// receiver stall shaping
	ready_mode_t ready_mode  = RDY_FREE;
	int          ready_pct   = 70;
	logic [11:0] ready_shape = 12'hfff;
	int          shape_pos   = 0;

	rgb888_to_hsv_rgb565 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.rgb565     (rgb565),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic pixel_hsv_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned rv, gv, bv, mx, mn, d, mag;
		pixel_hsv_t  px;
		rv = r;
		gv = g;
		bv = b;
		mx = (rv > gv) ? rv : gv;
		mx = (mx > bv) ? mx : bv;
		mn = (rv < gv) ? rv : gv;
		mn = (mn < bv) ? mn : bv;
		d  = mx - mn;

		px.rgb565 = 16'((((rv * 1000) / 8225) << 11) | (((gv * 1000) / 4047) << 5)
			| ((bv * 1000) / 8225));

		// blue wins ties over green, green over red
		if (d == 0)
			px.hue = 9'd0;
		else if (bv == mx)
			px.hue = 9'((240 * d + 60 * rv - 60 * gv) / d);
		else if (gv == mx)
			px.hue = 9'((120 * d + 60 * bv - 60 * rv) / d);
		else if (gv >= bv)
			px.hue = 9'((60 * (gv - bv)) / d);
		else begin
			// truncate toward zero, then wrap a negative angle
			mag = (60 * (bv - gv)) / d;
			px.hue = (mag == 0) ? 9'd0 : 9'(360 - mag);
		end

		px.saturation = (mx == 0) ? 7'd0 : 7'((100 * d) / mx);
		px.brightness = 7'((mx * 100) / 250);
		return px;
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_hsv.push_back(predict_hsv(r, g, b));
		if (burst_left > 0)
			burst_left--;
		else if (gap_max > 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(gap_max, 1)) @(posedge clk);
			burst_left = $urandom_range(burst_max, 0);
		end
	endtask

	task automatic wait_drained();
		while (expected_hsv.size() != 0)
			@(posedge clk);
	endtask

	// receiver: sample the transaction, then pick the next ready level
	always @(posedge clk) begin : check_results
		pixel_hsv_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_hsv.size() == 0) begin
				$error("result transaction with no pending input");
				error_count++;
			end else begin
				want = expected_hsv.pop_front();
				if (rgb565 !== want.rgb565) begin
					$error("rgb565: expected %h, got %h", want.rgb565, rgb565);
					error_count++;
				end
				if (hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hue);
					error_count++;
				end
				if (saturation !== want.saturation) begin
					$error("saturation: expected %0d, got %0d", want.saturation, saturation);
					error_count++;
				end
				if (brightness !== want.brightness) begin
					$error("brightness: expected %0d, got %0d", want.brightness, brightness);
					error_count++;
				end
			end
		end
		case (ready_mode)
			RDY_FREE: begin
				out_ready <= 1'b1;
			end
			RDY_RANDOM: begin
				out_ready <= ($urandom_range(99, 0) < ready_pct);
			end
			default: begin
				out_ready <= ready_shape[shape_pos];
				if (shape_pos == 11) begin
					shape_pos = 0;
					ready_shape = 12'($urandom) | 12'h001;
				end else
					shape_pos++;
			end
		endcase
	end

	task automatic test_corner_colours();
		gap_max    = 0;
		ready_mode = RDY_FREE;
		send_pixel(8'd0, 8'd0, 8'd0);        // black
		send_pixel(8'd255, 8'd255, 8'd255);  // white
		send_pixel(8'd128, 8'd128, 8'd128);  // grey
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
		send_pixel(8'd0, 8'd255, 8'd255);    // green and blue tie
		send_pixel(8'd255, 8'd0, 8'd255);    // red and blue tie
		send_pixel(8'd255, 8'd0, 8'd1);      // negative angle rounds to zero
		send_pixel(8'd255, 8'd0, 8'd10);     // negative angle wraps
		send_pixel(8'd255, 8'd10, 8'd0);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd254, 8'd1, 8'd127);
		send_pixel(8'haa, 8'h55, 8'haa);
		send_pixel(8'h55, 8'haa, 8'h55);
		send_pixel(8'd200, 8'd100, 8'd250);
		send_pixel(8'd10, 8'd200, 8'd5);
		send_pixel(8'd249, 8'd250, 8'd251);
		in_valid <= 1'b0;
		wait_drained();
	endtask

	task automatic test_uniform_random(input int count);
		burst_max  = 20;
		gap_max    = 6;
		ready_mode = RDY_RANDOM;
		ready_pct  = 70;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				ready_mode = RDY_PATTERN;
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_shaped_random(input int count);
		logic [7:0] c0, c1, c2, base;
		logic [7:0] ends[4];
		int         kind;
		ends[0] = 8'd0;
		ends[1] = 8'd1;
		ends[2] = 8'd254;
		ends[3] = 8'd255;
		burst_max  = 60;
		gap_max    = 4;
		ready_mode = RDY_PATTERN;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(7, 0);
			c0 = 8'($urandom);
			c1 = 8'($urandom);
			c2 = 8'($urandom);
			case (kind)
				0: begin
					c1 = c0;
					c2 = c0;
				end
				1: begin
					// two channels share the maximum
					if (c0 < c1)
						c0 = c1;
					c2 = (c2 > c0) ? c0 : c2;
					case ($urandom_range(2, 0))
						0: send_pixel(c0, c0, c2);
						1: send_pixel(c2, c0, c0);
						default: send_pixel(c0, c2, c0);
					endcase
				end
				2: begin
					// near grey, tiny spread
					base = 8'($urandom_range(252, 0));
					c0 = base + 8'($urandom_range(3, 0));
					c1 = base + 8'($urandom_range(3, 0));
					c2 = base + 8'($urandom_range(3, 0));
				end
				3: begin
					case ($urandom_range(2, 0))
						0: c0 = 8'd255;
						1: c1 = 8'd255;
						default: c2 = 8'd255;
					endcase
				end
				4: begin
					c0 = ends[$urandom_range(3, 0)];
					c1 = ends[$urandom_range(3, 0)];
					c2 = ends[$urandom_range(3, 0)];
				end
				default: begin
				end
			endcase
			if (kind != 1)
				send_pixel(c0, c1, c2);
		end
	endtask

	// sender holds off until the pipeline is empty, then restarts
	task automatic test_drain_pause(input int rounds);
		burst_max  = 30;
		gap_max    = 3;
		ready_mode = RDY_RANDOM;
		ready_pct  = 50;
		for (int n = 0; n < rounds; n++) begin
			for (int i = 0; i < 15; i++)
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			in_valid <= 1'b0;
			wait_drained();
		end
	endtask

	// backpressure heavy for half the pixels, then light, with no sender gaps; fills every stage
	task automatic test_backpressure(input int count);
		gap_max    = 0;
		ready_mode = RDY_RANDOM;
		ready_pct  = 10;
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				ready_pct = 90;
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_colours();
		test_uniform_random(450);
		test_shaped_random(400);
		test_drain_pause(6);
		test_backpressure(250);

		in_valid   <= 1'b0;
		ready_mode = RDY_RANDOM;
		ready_pct  = 60;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
